[hdl/tvrp_pkg.sv]
package tvrp_pkg;

	// Width of the running byte offset inside a vector.
	localparam int OFFSET_BITS = 16;

	// Depth of the queue between the front and the back.
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	// Flag bit positions.
	localparam int FLAG_REL  = 0;
	localparam int FLAG_WDF  = 1;
	localparam int FLAG_FREQ = 2;
	localparam int FLAG_POS  = 3;

	localparam logic [15:0] FREQ_BYTES    = 16'd4;
	localparam logic [15:0] POS_LEN_MIN   = 16'd2;

	// Parser phase.
	typedef enum logic [3:0] {
		PH_FLAG    = 4'd0,
		PH_KEYLEN  = 4'd1,
		PH_KEY     = 4'd2,
		PH_FREQ    = 4'd3,
		PH_WDF     = 4'd4,
		PH_POSHI   = 4'd5,
		PH_POSLO   = 4'd6,
		PH_POSBODY = 4'd7,
		PH_DONE    = 4'd8
	} tvrp_phase_t;

	// Sections that may follow, by what has just finished.
	typedef enum logic [1:0] {
		AFTER_KEY   = 2'd0,
		AFTER_FREQ  = 2'd1,
		AFTER_COUNT = 2'd2
	} tvrp_stage_t;

	// One word as tagged by the front.
	typedef struct packed {
		logic [7:0]             data;
		logic                   last;
		logic [OFFSET_BITS-1:0] pos;
	} tvrp_word_t;

	// One result descriptor.
	typedef struct packed {
		logic        status;
		logic [15:0] term_offset;
		logic [7:0]  term_length;
		logic        relevance;
		logic        has_frequency;
		logic [31:0] term_frequency;
		logic [7:0]  within_doc_count;
		logic        has_positions;
		logic [15:0] positions_offset;
		logic [15:0] positions_length;
	} tvrp_result_t;

	// Choose the section that follows the one just finished.
	function automatic tvrp_phase_t next_section(tvrp_stage_t stage, logic [3:0] flags);
		tvrp_phase_t ph;
		if (stage == AFTER_KEY && flags[FLAG_FREQ]) begin
			ph = PH_FREQ;
		end else if (stage != AFTER_COUNT && flags[FLAG_WDF]) begin
			ph = PH_WDF;
		end else if (flags[FLAG_POS]) begin
			ph = PH_POSHI;
		end else begin
			ph = PH_DONE;
		end
		return ph;
	endfunction

endpackage

[hdl/tvrp_front.sv]
module tvrp_front
	import tvrp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	input  logic       q_full,
	output logic       q_push,
	output tvrp_word_t q_word
);

	logic [OFFSET_BITS-1:0] pos_q;

	// Accept a word whenever the queue has room.
	assign in_ready = !q_full;
	assign q_push   = in_valid && !q_full;

	// Tag each word with its offset in the vector.
	assign q_word.data = data_byte;
	assign q_word.last = last_byte;
	assign q_word.pos  = pos_q;

	// The offset wraps and restarts after the last word of a vector.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (q_push) begin
			if (last_byte) begin
				pos_q <= '0;
			end else begin
				pos_q <= pos_q + OFFSET_BITS'(1);
			end
		end
	end

endmodule

[hdl/tvrp_queue.sv]
module tvrp_queue
	import tvrp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  tvrp_word_t push_word,
	output logic       full,
	input  logic       pop,
	output logic       not_empty,
	output tvrp_word_t pop_word
);

	tvrp_word_t             mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]    wr_q;
	logic [QUEUE_AW-1:0]    rd_q;
	logic [QUEUE_AW:0]      cnt_q;

	assign full      = (cnt_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign not_empty = (cnt_q != '0);
	assign pop_word  = mem_q[rd_q];

	// Storage of the queued words.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_word;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + QUEUE_AW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + QUEUE_AW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (QUEUE_AW+1)'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - (QUEUE_AW+1)'(1);
			end
		end
	end

endmodule

[hdl/tvrp_back.sv]
module tvrp_back
	import tvrp_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         q_not_empty,
	input  tvrp_word_t   q_word,
	output logic         q_pop,
	output logic         out_valid,
	input  logic         out_ready,
	output tvrp_result_t res
);

	tvrp_phase_t            phase_q;
	logic [3:0]             flags_q;
	logic [15:0]            left_q;
	logic [OFFSET_BITS-1:0] key_start_q;
	logic [7:0]             key_len_q;
	logic [31:0]            freq_q;
	logic [7:0]             count_q;
	logic [OFFSET_BITS-1:0] pos_start_q;
	logic [15:0]            pos_len_q;
	logic                   out_valid_q;
	tvrp_result_t           res_q;

	tvrp_phase_t            ph_d;
	tvrp_phase_t            phase_d;
	logic [3:0]             flags_d;
	logic [15:0]            left_d;
	logic [OFFSET_BITS-1:0] key_start_d;
	logic [7:0]             key_len_d;
	logic [31:0]            freq_d;
	logic [7:0]             count_d;
	logic [OFFSET_BITS-1:0] pos_start_d;
	logic [15:0]            pos_len_d;
	logic                   emit;
	tvrp_result_t           res_d;

	// A word is taken when the output register is free or being emptied.
	assign q_pop     = q_not_empty && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign res       = res_q;

	// Next state of the parser for the word at the head of the queue.
	always_comb begin
		ph_d        = phase_q;
		flags_d     = flags_q;
		left_d      = left_q;
		key_start_d = key_start_q;
		key_len_d   = key_len_q;
		freq_d      = freq_q;
		count_d     = count_q;
		pos_start_d = pos_start_q;
		pos_len_d   = pos_len_q;
		case (phase_q)
			PH_KEYLEN: begin
				key_len_d = (q_word.data == 8'd0) ? 8'd1 : q_word.data;
				left_d    = 16'(key_len_d) - 16'd1;
				ph_d      = (left_d != '0) ? PH_KEY : next_section(AFTER_KEY, flags_q);
			end
			PH_KEY: begin
				left_d = left_q - 16'd1;
				if (left_d == '0) begin
					ph_d = next_section(AFTER_KEY, flags_q);
				end
			end
			PH_FREQ: begin
				freq_d = {freq_q[23:0], q_word.data};
				left_d = left_q - 16'd1;
				if (left_d == '0) begin
					ph_d = next_section(AFTER_FREQ, flags_q);
				end
			end
			PH_WDF: begin
				count_d = q_word.data;
				ph_d    = next_section(AFTER_COUNT, flags_q);
			end
			PH_POSHI: begin
				pos_start_d = q_word.pos;
				pos_len_d   = {q_word.data, 8'd0};
				ph_d        = PH_POSLO;
			end
			PH_POSLO: begin
				pos_len_d = {pos_len_q[15:8], q_word.data};
				if (pos_len_d < POS_LEN_MIN) begin
					pos_len_d = POS_LEN_MIN;
				end
				left_d = pos_len_d - POS_LEN_MIN;
				ph_d   = (left_d != '0) ? PH_POSBODY : PH_DONE;
			end
			PH_POSBODY: begin
				left_d = left_q - 16'd1;
				if (left_d == '0) begin
					ph_d = PH_DONE;
				end
			end
			default: begin
				flags_d     = q_word.data[3:0];
				key_start_d = q_word.pos + OFFSET_BITS'(1);
				key_len_d   = '0;
				freq_d      = '0;
				count_d     = '0;
				pos_start_d = '0;
				pos_len_d   = '0;
				ph_d        = PH_KEYLEN;
			end
		endcase
		// Entering the frequency field loads its byte count.
		if (ph_d == PH_FREQ && phase_q != PH_FREQ) begin
			left_d = FREQ_BYTES;
		end
		// A finished term or the end of the vector returns to the flag byte.
		if (ph_d == PH_DONE || q_word.last) begin
			phase_d = PH_FLAG;
		end else begin
			phase_d = ph_d;
		end
	end

	// Descriptor for the word at the head of the queue.
	always_comb begin
		res_d = '0;
		emit  = 1'b0;
		if (ph_d == PH_DONE) begin
			emit                   = 1'b1;
			res_d.status           = 1'b0;
			res_d.term_offset      = 16'(key_start_d);
			res_d.term_length      = key_len_d;
			res_d.relevance        = flags_d[FLAG_REL];
			res_d.has_frequency    = flags_d[FLAG_FREQ];
			res_d.term_frequency   = freq_d;
			res_d.within_doc_count = count_d;
			res_d.has_positions    = flags_d[FLAG_POS];
			res_d.positions_offset = 16'(pos_start_d);
			res_d.positions_length = pos_len_d;
		end else if (q_word.last && ph_d != PH_KEYLEN) begin
			// Vector ended inside a term.
			emit              = 1'b1;
			res_d.status      = 1'b1;
			res_d.term_offset = 16'(key_start_d);
		end
	end

	// Parser state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_FLAG;
			flags_q     <= '0;
			left_q      <= '0;
			key_start_q <= '0;
			key_len_q   <= '0;
			freq_q      <= '0;
			count_q     <= '0;
			pos_start_q <= '0;
			pos_len_q   <= '0;
		end else if (q_pop) begin
			phase_q     <= phase_d;
			flags_q     <= flags_d;
			left_q      <= left_d;
			key_start_q <= key_start_d;
			key_len_q   <= key_len_d;
			freq_q      <= freq_d;
			count_q     <= count_d;
			pos_start_q <= pos_start_d;
			pos_len_q   <= pos_len_d;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (q_pop && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && emit) begin
			res_q <= res_d;
		end
	end

endmodule

[hdl/term_vector_record_parser_core.sv]
// Term vector record parser: takes the body of a term vector one byte per word, starting at
// the first flag byte, and gives one descriptor per completed term, or a descriptor with
// status set when a vector ends inside a term. A word is accepted every cycle while the
// queue has room; a byte reaches the parser through a two-word queue, and its descriptor is
// then loaded into the output register. The single parser state machine, which handles
// one byte per cycle while the output register is free or being emptied, sets the throughput.
module term_vector_record_parser_core
	import tvrp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        status,
	output logic [15:0] term_offset,
	output logic [7:0]  term_length,
	output logic        relevance,
	output logic        has_frequency,
	output logic [31:0] term_frequency,
	output logic [7:0]  within_doc_count,
	output logic        has_positions,
	output logic [15:0] positions_offset,
	output logic [15:0] positions_length
);

	logic         q_full;
	logic         q_push;
	logic         q_pop;
	logic         q_not_empty;
	tvrp_word_t   push_word;
	tvrp_word_t   head_word;
	tvrp_result_t res;

	// Front: accepts and tags words.
	tvrp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_word    (push_word)
	);

	// Queue between the front and the parser.
	tvrp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_word (push_word),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.pop_word  (head_word)
	);

	// Back: parser and output register.
	tvrp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_word      (head_word),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.res         (res)
	);

	assign status           = res.status;
	assign term_offset      = res.term_offset;
	assign term_length      = res.term_length;
	assign relevance        = res.relevance;
	assign has_frequency    = res.has_frequency;
	assign term_frequency   = res.term_frequency;
	assign within_doc_count = res.within_doc_count;
	assign has_positions    = res.has_positions;
	assign positions_offset = res.positions_offset;
	assign positions_length = res.positions_length;

endmodule

[sim/tb_term_vector_record_parser_core.sv]
module tb_term_vector_record_parser_core;
	import tvrp_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 20;
	localparam int MAX_REPORTS = 10;

	// One word waiting to be offered, with a request to wait for all descriptors first.
	typedef struct {
		logic [7:0] data;
		logic       last;
		bit         pause;
	} feed_word_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = 8'd0;
	logic        last_byte = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        status;
	logic [15:0] term_offset;
	logic [7:0]  term_length;
	logic        relevance;
	logic        has_frequency;
	logic [31:0] term_frequency;
	logic [7:0]  within_doc_count;
	logic        has_positions;
	logic [15:0] positions_offset;
	logic [15:0] positions_length;

	tvrp_result_t seen_desc;

	// Pending words, words of the vector being built and descriptors still owed.
	feed_word_t   feed_q[$];
	logic [7:0]   vec_bytes[$];
	tvrp_result_t desc_q[$];
	feed_word_t   drv_word;

	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int rx_hold_reqs = 0;
	int rx_hold_done;
	int rx_hold_left;
	int words_queued = 0;
	int words_taken = 0;
	int desc_seen = 0;
	int desc_trunc = 0;
	int desc_errors = 0;
	int cycle_cnt = 0;

	// Parser state as the testbench expects it.
	tvrp_phase_t prs_phase = PH_FLAG;
	logic [3:0]  prs_flags = '0;
	logic [15:0] prs_pos = '0;
	logic [15:0] prs_left = '0;
	logic [15:0] prs_key_start = '0;
	logic [7:0]  prs_key_len = '0;
	logic [31:0] prs_freq = '0;
	logic [7:0]  prs_count = '0;
	logic [15:0] prs_pos_start = '0;
	logic [15:0] prs_pos_len = '0;

	term_vector_record_parser_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_byte(data_byte),
		.last_byte(last_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.term_offset(term_offset),
		.term_length(term_length),
		.relevance(relevance),
		.has_frequency(has_frequency),
		.term_frequency(term_frequency),
		.within_doc_count(within_doc_count),
		.has_positions(has_positions),
		.positions_offset(positions_offset),
		.positions_length(positions_length)
	);

	assign seen_desc = {status, term_offset, term_length, relevance, has_frequency,
		term_frequency, within_doc_count, has_positions, positions_offset, positions_length};

	// The section after the key, the frequency or the count, as the flags select it.
	task automatic pick_section(input tvrp_stage_t finished);
		if (finished == AFTER_KEY && prs_flags[FLAG_FREQ]) begin
			prs_phase = PH_FREQ;
			prs_left = FREQ_BYTES;
		end else if (finished != AFTER_COUNT && prs_flags[FLAG_WDF]) begin
			prs_phase = PH_WDF;
		end else if (prs_flags[FLAG_POS]) begin
			prs_phase = PH_POSHI;
		end else begin
			prs_phase = PH_DONE;
		end
	endtask

	// Advance the expected parser by one accepted word and queue any descriptor it owes.
	task automatic parse_byte(input logic [7:0] b, input logic lst);
		logic [15:0]  here;
		tvrp_result_t d;
		here = prs_pos;
		case (prs_phase)
			PH_KEYLEN: begin
				prs_key_len = (b == 8'd0) ? 8'd1 : b;
				prs_left = {8'd0, prs_key_len} - 16'd1;
				if (prs_left != 16'd0) prs_phase = PH_KEY;
				else pick_section(AFTER_KEY);
			end
			PH_KEY: begin
				prs_left = prs_left - 16'd1;
				if (prs_left == 16'd0) pick_section(AFTER_KEY);
			end
			PH_FREQ: begin
				prs_freq = {prs_freq[23:0], b};
				prs_left = prs_left - 16'd1;
				if (prs_left == 16'd0) pick_section(AFTER_FREQ);
			end
			PH_WDF: begin
				prs_count = b;
				pick_section(AFTER_COUNT);
			end
			PH_POSHI: begin
				prs_pos_start = here;
				prs_pos_len = {b, 8'd0};
				prs_phase = PH_POSLO;
			end
			PH_POSLO: begin
				prs_pos_len = prs_pos_len | {8'd0, b};
				if (prs_pos_len < POS_LEN_MIN) prs_pos_len = POS_LEN_MIN;
				prs_left = prs_pos_len - POS_LEN_MIN;
				prs_phase = (prs_left != 16'd0) ? PH_POSBODY : PH_DONE;
			end
			PH_POSBODY: begin
				prs_left = prs_left - 16'd1;
				if (prs_left == 16'd0) prs_phase = PH_DONE;
			end
			default: begin
				prs_flags = b[3:0];
				prs_key_start = here + 16'd1;
				prs_key_len = '0;
				prs_freq = '0;
				prs_count = '0;
				prs_pos_start = '0;
				prs_pos_len = '0;
				prs_phase = PH_KEYLEN;
			end
		endcase

		d = '0;
		if (prs_phase == PH_DONE) begin
			d.term_offset = prs_key_start;
			d.term_length = prs_key_len;
			d.relevance = prs_flags[FLAG_REL];
			d.has_frequency = prs_flags[FLAG_FREQ];
			d.term_frequency = prs_freq;
			d.within_doc_count = prs_count;
			d.has_positions = prs_flags[FLAG_POS];
			d.positions_offset = prs_pos_start;
			d.positions_length = prs_pos_len;
			desc_q.push_back(d);
			prs_phase = PH_FLAG;
		end else if (lst) begin
			// A vector that stops on its flag byte owes nothing; anywhere else it is truncated.
			if (prs_phase != PH_KEYLEN) begin
				d.status = 1'b1;
				d.term_offset = prs_key_start;
				desc_q.push_back(d);
			end
			prs_phase = PH_FLAG;
		end
		prs_pos = lst ? 16'd0 : here + 16'd1;
	endtask

	function automatic string desc_text(input tvrp_result_t d);
		return $sformatf("st=%0d off=%h len=%h rel=%0d hf=%0d freq=%h wdc=%h hp=%0d poff=%h plen=%h",
			d.status, d.term_offset, d.term_length, d.relevance, d.has_frequency,
			d.term_frequency, d.within_doc_count, d.has_positions, d.positions_offset,
			d.positions_length);
	endfunction

	task automatic push_rand(input int n);
		for (int i = 0; i < n; i++) vec_bytes.push_back(8'($urandom_range(255)));
	endtask

	// Append one well-formed term with random key, frequency, count and position bytes.
	task automatic build_term(input logic [7:0] flag, input logic [7:0] klen,
			input logic [15:0] plen);
		vec_bytes.push_back(flag);
		vec_bytes.push_back(klen);
		push_rand((klen == 8'd0) ? 0 : int'(klen) - 1);
		if (flag[FLAG_FREQ]) push_rand(4);
		if (flag[FLAG_WDF]) push_rand(1);
		if (flag[FLAG_POS]) begin
			vec_bytes.push_back(plen[15:8]);
			vec_bytes.push_back(plen[7:0]);
			push_rand((plen < POS_LEN_MIN) ? 0 : int'(plen) - 2);
		end
	endtask

	// Move the built vector to the feed, ending it on the word at index cut.
	task automatic flush_vector(input int cut, input bit pause);
		feed_word_t w;
		for (int i = 0; i <= cut; i++) begin
			w.data = vec_bytes[i];
			w.last = (i == cut);
			w.pause = pause && (i == 0);
			feed_q.push_back(w);
		end
		words_queued += cut + 1;
		vec_bytes.delete();
	endtask

	// Random vectors: mostly well-formed terms, some truncated, some with a lone flag
	// byte at the end and a few of plain noise.
	task automatic random_vectors(input int budget, input bit pause_first);
		int          target;
		int          choice;
		bit          pause;
		logic [7:0]  klen;
		logic [15:0] plen;
		target = words_queued + budget;
		pause = pause_first;
		while (words_queued < target) begin
			repeat ($urandom_range(1, 4)) begin
				case ($urandom_range(39))
					0: klen = 8'd0;
					1: klen = 8'd255;
					2, 3: klen = 8'($urandom_range(255));
					default: klen = 8'($urandom_range(1, 8));
				endcase
				case ($urandom_range(19))
					0: plen = {8'd0, 8'($urandom_range(255))};
					1: plen = {8'd1, 8'($urandom_range(255))};
					default: plen = 16'($urandom_range(12));
				endcase
				build_term(8'($urandom_range(255)), klen, plen);
			end
			choice = $urandom_range(19);
			if (choice <= 2) begin
				flush_vector($urandom_range(vec_bytes.size() - 1), pause);
			end else if (choice == 3) begin
				vec_bytes.push_back(8'($urandom_range(255)));
				flush_vector(vec_bytes.size() - 1, pause);
			end else if (choice == 4) begin
				vec_bytes.delete();
				push_rand($urandom_range(1, 6));
				flush_vector(vec_bytes.size() - 1, pause);
			end else begin
				flush_vector(vec_bytes.size() - 1, pause);
			end
			pause = ($urandom_range(9) == 0);
		end
	endtask

	// Clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Driver: offers the next pending word when the input slot is free.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			data_byte <= 8'd0;
			last_byte <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				parse_byte(data_byte, last_byte);
				words_taken <= words_taken + 1;
			end
			if (!in_valid || in_ready) begin
				if (feed_q.size() != 0 && !(feed_q[0].pause && desc_q.size() != 0) &&
						$urandom_range(99) >= tx_idle_pct) begin
					drv_word = feed_q.pop_front();
					data_byte <= drv_word.data;
					last_byte <= drv_word.last;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: random ready, or a long hold-off when one is requested.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_hold_left <= 0;
			rx_hold_done <= 0;
		end else if (rx_hold_left != 0) begin
			out_ready <= 1'b0;
			rx_hold_left <= rx_hold_left - 1;
		end else if (rx_hold_done < rx_hold_reqs) begin
			out_ready <= 1'b0;
			rx_hold_done <= rx_hold_done + 1;
			rx_hold_left <= HOLD_CYCLES;
		end else begin
			out_ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// Monitor: each accepted descriptor against the oldest one owed.
	always @(posedge clk) begin
		tvrp_result_t owed;
		if (arst_n && out_valid && out_ready) begin
			desc_seen <= desc_seen + 1;
			if (desc_q.size() == 0) begin
				desc_errors <= desc_errors + 1;
				if (desc_errors < MAX_REPORTS)
					$display("unexpected descriptor: %s", desc_text(seen_desc));
			end else begin
				owed = desc_q.pop_front();
				if (owed.status) desc_trunc <= desc_trunc + 1;
				if (seen_desc !== owed) begin
					desc_errors <= desc_errors + 1;
					if (desc_errors < MAX_REPORTS) begin
						$display("descriptor %0d mismatch", desc_seen);
						$display("  expected %s", desc_text(owed));
						$display("  actual   %s", desc_text(seen_desc));
					end
				end
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d descriptors still owed", cycle_cnt,
				desc_q.size());
			$display("tb_term_vector_record_parser_core: done, errors");
			$finish;
		end
	end

	// Stimulus and end of run.
	initial begin
		int mark;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Phase one: slow sender, slower receiver.
		tx_idle_pct = 29;
		rx_idle_pct = 85;

		// A lone flag byte with its high bits set ends the vector quietly.
		vec_bytes = '{8'hF0};
		flush_vector(0, 1'b0);
		// Zero key length, the term ending on the last word.
		vec_bytes = '{8'h00, 8'h00};
		flush_vector(1, 1'b0);
		// Every flag, all-ones frequency and count, and a position length below two.
		vec_bytes = '{8'h0F, 8'h02, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h01};
		flush_vector(9, 1'b0);
		// Vector ending inside the key.
		vec_bytes = '{8'h04, 8'h03, 8'h55};
		flush_vector(2, 1'b0);
		// Zero position length, the term ending on the last word.
		vec_bytes = '{8'h08, 8'h01, 8'h00, 8'h00};
		flush_vector(3, 1'b0);
		// Vector ending inside the position block.
		vec_bytes = '{8'h08, 8'h01, 8'h00, 8'h05, 8'hAA};
		flush_vector(4, 1'b0);

		random_vectors(250, 1'b1);
		while (feed_q.size() != 0) @(negedge clk);

		// Phase two: the other way round.
		tx_idle_pct = 85;
		rx_idle_pct = 29;
		random_vectors(250, 1'b1);
		while (feed_q.size() != 0) @(negedge clk);

		// Phase three: no idling, with a long receiver hold-off while the sender keeps
		// offering.
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		build_term(8'h08, 8'd1, 16'd40);
		build_term(8'h0F, 8'd3, 16'd2);
		build_term(8'h05, 8'd2, 16'd0);
		flush_vector(vec_bytes.size() - 1, 1'b1);
		// A position length with every bit set, the vector ending inside the block.
		vec_bytes = '{8'h08, 8'h01, 8'hFF, 8'hFF, 8'hAA};
		flush_vector(4, 1'b0);
		random_vectors(250, 1'b0);
		mark = words_taken;
		while (words_taken < mark + 20) @(negedge clk);
		rx_hold_reqs = rx_hold_reqs + 1;

		while (feed_q.size() != 0 || in_valid || desc_q.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("%0d words in three idling patterns, %0d descriptors checked, %0d truncated",
			words_taken, desc_seen, desc_trunc);
		$display("mismatches %0d, descriptors left owed %0d", desc_errors, desc_q.size());
		if (desc_errors == 0 && desc_q.size() == 0) begin
			$display("tb_term_vector_record_parser_core: done, clean");
		end else begin
			$display("tb_term_vector_record_parser_core: done, errors");
		end
		$finish;
	end

endmodule

[filelist.f]
hdl/tvrp_pkg.sv
hdl/tvrp_front.sv
hdl/tvrp_queue.sv
hdl/tvrp_back.sv
hdl/term_vector_record_parser_core.sv
sim/tb_term_vector_record_parser_core.sv
